@@ rtl/sle_pkg.sv @@
`timescale 1ns / 1ps

package sle_pkg;

  localparam int LINE_CAPACITY = 62;
  localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);
  localparam int ADDR_W        = $clog2(LINE_CAPACITY);

  localparam logic [7:0] CH_ETX       = 8'h03;
  localparam logic [7:0] CH_BEL       = 8'h07;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_SP        = 8'h20;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_DEL       = 8'h7F;
  localparam logic [7:0] CSI_FINAL_LO = 8'h40;
  localparam logic [7:0] CSI_FINAL_HI = 8'h7E;

  localparam int ACT_W = 3;
  localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_NEWLINE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ERASE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STORE   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_BELL    = 3'd5;

  typedef struct packed {
    logic rd_fill;
    logic load_in;
    logic commit;
    logic load_term;
    logic line_rd;
    logic load_line;
    logic fill_clr;
  } sle_cmd_t;

  typedef struct packed {
    logic [1:0] n_term;
    logic       term_end;
    logic       line_pend;
    logic       line_end;
    logic       out_free;
  } sle_stat_t;

  function automatic logic [7:0] term_byte(input logic [ACT_W-1:0] act,
                                           input logic [1:0]       k,
                                           input logic [7:0]       c);
    logic [7:0] b;
    b = 8'h00;
    unique case (act)
      ACT_NEWLINE, ACT_CLEAR: b = (k == 2'd0) ? CH_CR : CH_LF;
      ACT_ERASE:              b = (k == 2'd1) ? CH_SP : CH_BS;
      ACT_STORE:              b = c;
      ACT_BELL:               b = CH_BEL;
      default:                b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/sle_ctrl.sv @@
`timescale 1ns / 1ps

module sle_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  sle_pkg::sle_stat_t stat,
  output sle_pkg::sle_cmd_t  cmd
);
  import sle_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_TERM   = 3'd2;
  localparam logic [2:0] ST_LREAD  = 3'd3;
  localparam logic [2:0] ST_LPUSH  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.rd_fill = 1'b1;
        cmd.load_in = in_tvalid;
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        cmd.commit = 1'b1;
        state_nxt  = (stat.n_term == 2'd0) ? ST_IDLE : ST_TERM;
      end
      ST_TERM: begin
        if (stat.out_free) begin
          cmd.load_term = 1'b1;
          if (stat.term_end) begin
            state_nxt = stat.line_pend ? ST_LREAD : ST_IDLE;
          end
        end
      end
      ST_LREAD: begin
        cmd.line_rd = 1'b1;
        state_nxt   = ST_LPUSH;
      end
      ST_LPUSH: begin
        if (stat.out_free) begin
          cmd.load_line = 1'b1;
          if (stat.line_end) begin
            cmd.fill_clr = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_LREAD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/sle_dp.sv @@
`timescale 1ns / 1ps

module sle_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       in_tdata,
  input  logic             cfg_valid,
  input  logic             cfg_data,
  input  sle_pkg::sle_cmd_t  cmd,
  output sle_pkg::sle_stat_t stat,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);
  import sle_pkg::*;

  logic [6:0]       line_mem [0:LINE_CAPACITY-1];
  logic [6:0]       rd_r;
  logic [ADDR_W-1:0] rd_addr;

  logic [7:0]       rx_r;
  logic             echo_r;
  logic             esc_r, esc_nxt;
  logic             csi_r, csi_nxt;
  logic             cr_r, cr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] fill_m1;
  logic [ACT_W-1:0] act_r, act_nxt;
  logic [1:0]       n_term_r, n_term_nxt;
  logic [1:0]       term_idx_r;
  logic [ADDR_W-1:0] line_idx_r;
  logic             wr_en;
  logic             run;
  logic             room;

  logic             out_tvalid_r;
  logic [7:0]       out_tdata_r;
  logic             out_tuser_r;
  logic             out_tlast_r;

  assign fill_m1 = fill_r - CNT_W'(1);
  assign room    = (fill_r < CNT_W'(LINE_CAPACITY));

  // decode of the held byte against the editor state
  always_comb begin
    esc_nxt  = esc_r;
    csi_nxt  = csi_r;
    cr_nxt   = cr_r;
    fill_nxt = fill_r;
    act_nxt  = ACT_NONE;
    wr_en    = 1'b0;
    run      = 1'b0;
    priority if (esc_r) begin
      esc_nxt = 1'b0;
      if (rx_r == CH_LBRACKET) csi_nxt = 1'b1;
      else run = 1'b1;
    end else if (csi_r) begin
      if (rx_r >= CSI_FINAL_LO && rx_r <= CSI_FINAL_HI) csi_nxt = 1'b0;
    end else begin
      run = 1'b1;
    end
    // lf straight after cr is swallowed
    if (run && cr_r) begin
      cr_nxt = 1'b0;
      if (rx_r == CH_LF) run = 1'b0;
    end
    if (run) begin
      unique case (rx_r)
        CH_CR, CH_LF: begin
          if (rx_r == CH_CR) cr_nxt = 1'b1;
          act_nxt = ACT_NEWLINE;
        end
        CH_BS, CH_DEL: begin
          if (fill_r != '0) begin
            fill_nxt = fill_m1;
            act_nxt  = ACT_ERASE;
          end
        end
        CH_ETX: begin
          fill_nxt = '0;
          act_nxt  = ACT_CLEAR;
        end
        CH_ESC: esc_nxt = 1'b1;
        CH_SP: begin
          if (fill_r != '0 && room && rd_r != CH_SP[6:0]) begin
            wr_en    = 1'b1;
            fill_nxt = fill_r + CNT_W'(1);
            act_nxt  = ACT_STORE;
          end
        end
        default: begin
          if (rx_r > CH_SP && rx_r < CH_DEL) begin
            if (room) begin
              wr_en    = 1'b1;
              fill_nxt = fill_r + CNT_W'(1);
              act_nxt  = ACT_STORE;
            end else begin
              act_nxt = ACT_BELL;
            end
          end
        end
      endcase
    end
    unique case (act_nxt)
      ACT_NEWLINE, ACT_CLEAR: n_term_nxt = 2'd2;
      ACT_ERASE:              n_term_nxt = echo_r ? 2'd3 : 2'd0;
      ACT_STORE, ACT_BELL:    n_term_nxt = echo_r ? 2'd1 : 2'd0;
      default:                n_term_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r <= 1'b1;
      esc_r  <= 1'b0;
      csi_r  <= 1'b0;
      cr_r   <= 1'b0;
      fill_r <= '0;
    end else begin
      if (cfg_valid) echo_r <= cfg_data;
      if (cmd.commit) begin
        esc_r <= esc_nxt;
        csi_r <= csi_nxt;
        cr_r  <= cr_nxt;
        // a newline keeps the count until the line has been sent
        if (act_nxt != ACT_NEWLINE) fill_r <= fill_nxt;
      end else if (cmd.fill_clr) begin
        fill_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) rx_r <= in_tdata;
    if (cmd.commit) begin
      act_r      <= act_nxt;
      n_term_r   <= n_term_nxt;
      term_idx_r <= 2'd0;
      line_idx_r <= '0;
    end else begin
      if (cmd.load_term) term_idx_r <= term_idx_r + 2'd1;
      if (cmd.load_line) line_idx_r <= line_idx_r + ADDR_W'(1);
    end
  end

  // line store, one write and one registered read port
  assign rd_addr = cmd.line_rd ? line_idx_r :
                   (fill_r == '0) ? '0 : fill_m1[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) line_mem[fill_r[ADDR_W-1:0]] <= rx_r[6:0];
    if (cmd.rd_fill || cmd.line_rd) rd_r <= line_mem[rd_addr];
  end

  assign stat.n_term    = n_term_nxt;
  assign stat.term_end  = (term_idx_r == n_term_r - 2'd1);
  assign stat.line_pend = (act_r == ACT_NEWLINE) && (fill_r != '0);
  assign stat.line_end  = (CNT_W'(line_idx_r) == fill_m1);
  assign stat.out_free  = !out_tvalid_r || out_tready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_term || cmd.load_line) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_term) begin
      out_tdata_r <= term_byte(act_r, term_idx_r, rx_r);
      out_tuser_r <= 1'b0;
      out_tlast_r <= stat.term_end && !stat.line_pend;
    end else if (cmd.load_line) begin
      out_tdata_r <= {1'b0, rd_r};
      out_tuser_r <= 1'b1;
      out_tlast_r <= stat.line_end;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

@@ rtl/serial_line_editor_unit.sv @@
`timescale 1ns / 1ps

// serial line editor: builds a command line from received terminal bytes
// in_*  : one received byte per transfer, in_tdata = rx_byte
// out_* : results, out_tdata = terminal byte or line byte,
//         out_tuser = channel (0 terminal, 1 completed line),
//         out_tlast = final result caused by the input byte
// cfg_* : echo_enable, taken in any cycle; cfg_ready is always high
// an input byte is decoded in the cycle after its transfer; its first result
// is loaded into the output register from the terminal state after decode;
// terminal results follow one per cycle while out_tready allows, completed
// line bytes alternate a read of the line store and a push, set by the
// single registered read port of the line store
// in_tready is high only while no byte is being worked on: a byte is held
// through its decode, its terminal results and its completed line bytes
// a stalled out_tready holds the output register and freezes the sequence
// reset (rst_n low, synchronous) empties the line, clears escape state,
// drops any pending result and sets echo on
module serial_line_editor_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] channel
  output logic       out_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import sle_pkg::*;

  sle_cmd_t  cmd;
  sle_stat_t stat;

  assign cfg_ready = 1'b1;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sle_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/sle_chk.sv @@
`timescale 1ns / 1ps

module sle_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // a byte is decoded before the next one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while decoding");

  // more results owed for the current byte keep input closed
  a_no_accept_mid_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open before final result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind serial_line_editor_unit sle_chk u_sle_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
